[src/rws_pkg.sv]
`timescale 1ns / 1ps
package rws_pkg;

  localparam int GENE_W       = 17;
  localparam int SLOT_W       = 7;
  localparam int DIST_W       = 19;
  localparam int FIT_W        = 32;
  localparam int POP_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_POP_DEF  = 128;
  localparam int POP_RESET    = 100;
  localparam int DRAW_SCALE   = 100000;
  localparam int SCALE_W      = 17;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_C   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE = 2'd3;

  // item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // one classified item between front and back
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] l1_dist;
    logic [GENE_W-1:0] draw;
  } rws_item_t;

endpackage

[src/rws_front.sv]
`timescale 1ns / 1ps
module rws_front import rws_pkg::*; #(
  parameter int MAX_POPULATION = MAX_POP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [SLOT_W-1:0] slot,
  input  logic [GENE_W-1:0] gene_a,
  input  logic [GENE_W-1:0] gene_b,
  input  logic [GENE_W-1:0] gene_c,
  input  logic [GENE_W-1:0] draw,
  input  logic [GENE_W-1:0] goal_a,
  input  logic [GENE_W-1:0] goal_b,
  input  logic [GENE_W-1:0] goal_c,
  output logic              q_push,
  output rws_item_t         q_item,
  input  logic              q_ready
);

  logic              f_valid;
  logic              keep;
  logic              take;
  logic [GENE_W-1:0] da;
  logic [GENE_W-1:0] db;
  logic [GENE_W-1:0] dc;
  logic [DIST_W-1:0] l1_dist;

  // l1 distance to the goal genes
  always_comb begin
    da      = (gene_a > goal_a) ? gene_a - goal_a : goal_a - gene_a;
    db      = (gene_b > goal_b) ? gene_b - goal_b : goal_b - gene_b;
    dc      = (gene_c > goal_c) ? gene_c - goal_c : goal_c - gene_c;
    l1_dist = DIST_W'(da) + DIST_W'(db) + DIST_W'(dc);
  end

  // loads beyond the table are dropped here
  assign keep     = (mode == MODE_SELECT) || (int'(slot) < MAX_POPULATION);
  assign q_push   = f_valid && q_ready;
  assign in_stall = f_valid && !q_ready;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!f_valid || q_push) begin
      f_valid <= take && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_item.mode    <= mode;
      q_item.slot    <= slot;
      q_item.l1_dist <= l1_dist;
      q_item.draw    <= draw;
    end
  end

endmodule

[src/rws_queue.sv]
`timescale 1ns / 1ps
module rws_queue import rws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rws_item_t push_item,
  output logic      ready,
  input  logic      pop,
  output logic      head_valid,
  output rws_item_t head
);

  rws_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  // two-entry fifo
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[src/rws_back.sv]
`timescale 1ns / 1ps
module rws_back import rws_pkg::*; #(
  parameter int MAX_POPULATION = MAX_POP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  rws_item_t                            q_head,
  output logic                                 q_pop,
  input  logic [$clog2(MAX_POPULATION+1)-1:0] pop_n,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [SLOT_W-1:0]                    chosen_slot,
  output logic                                 found
);

  localparam int IW     = $clog2(MAX_POPULATION);
  localparam int NW     = $clog2(MAX_POPULATION+1);
  localparam int TOT_W  = FIT_W + IW;
  localparam int HALF   = TOT_W / 2;
  localparam int LHS_W  = TOT_W + SCALE_W;
  localparam int PROD_W = FIT_W + SCALE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WRITE, S_SUM, S_MUL_LO, S_MUL_HI, S_LHS, S_WALK
  } state_t;

  state_t state;

  rws_item_t cur;

  // fitness table and valid bits
  logic [FIT_W-1:0] fit_mem [MAX_POPULATION];
  logic [MAX_POPULATION-1:0] slot_valid;
  logic             wr_en;
  logic [FIT_W-1:0] wr_data;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [FIT_W-1:0] rd_data;

  // divider
  logic [DIST_W-1:0] rem;
  logic [DIST_W:0]   trial;
  logic [FIT_W:0]    quo;
  logic [5:0]        div_cnt;

  // walk
  logic [NW-1:0]          issue_cnt;
  logic                   issue_done;
  logic                   s1_v;
  logic                   s1_ok;
  logic [IW-1:0]          s1_idx;
  logic                   s2_v;
  logic                   s2_ok;
  logic [IW-1:0]          s2_idx;
  logic [PROD_W-1:0]      s2_prod;
  logic [TOT_W-1:0]       total;
  logic [SCALE_W+HALF-1:0]         plo;
  logic [SCALE_W+TOT_W-HALF-1:0]   phi;
  logic [LHS_W-1:0]       lhs;
  logic [LHS_W-1:0]       scaled;
  logic [LHS_W-1:0]       scaled_next;
  logic                   hit;
  logic [IW-1:0]          hit_idx;
  logic                   emit;
  logic                   out_free;

  assign q_pop      = (state == S_IDLE) && q_valid && !emit;
  assign issue_done = (issue_cnt == pop_n);
  assign rd_en      = ((state == S_SUM) || (state == S_WALK)) && !issue_done && !hit;
  assign rd_addr    = issue_cnt[IW-1:0];
  assign wr_en      = (state == S_WRITE);
  assign wr_data    = quo[FIT_W] ? {FIT_W{1'b1}} : quo[FIT_W-1:0];
  assign trial      = {rem, (div_cnt == 6'd0)};
  assign scaled_next = scaled + LHS_W'(s2_prod);
  assign out_free   = !out_valid || !out_stall;

  // fitness memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) fit_mem[IW'(cur.slot)] <= wr_data;
    if (rd_en) rd_data <= fit_mem[rd_addr];
  end

  // walk pipeline payload
  always_ff @(posedge clk) begin
    s1_idx  <= rd_addr;
    s1_ok   <= slot_valid[rd_addr];
    s2_idx  <= s1_idx;
    s2_ok   <= s1_ok;
    s2_prod <= PROD_W'(rd_data) * PROD_W'(DRAW_SCALE);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      hit        <= 1'b0;
      emit       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_v <= rd_en;
      s2_v <= s1_v && (state == S_WALK);
      // result beat into the output register
      if (emit && out_free) begin
        out_valid   <= 1'b1;
        found       <= hit;
        chosen_slot <= hit ? SLOT_W'(hit_idx) : '0;
        emit        <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur       <= q_head;
            rem       <= '0;
            quo       <= '0;
            div_cnt   <= '0;
            issue_cnt <= '0;
            total     <= '0;
            hit       <= 1'b0;
            state     <= (q_head.mode == MODE_LOAD) ? S_DIV : S_SUM;
          end
        end
        S_DIV: begin
          // one quotient bit of 2^32 / distance per cycle
          if (trial >= {1'b0, cur.l1_dist}) begin
            rem <= DIST_W'(trial - {1'b0, cur.l1_dist});
            quo <= {quo[FIT_W-1:0], 1'b1};
          end else begin
            rem <= DIST_W'(trial);
            quo <= {quo[FIT_W-1:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(FIT_W)) state <= S_WRITE;
        end
        S_WRITE: begin
          slot_valid[IW'(cur.slot)] <= 1'b1;
          state <= S_IDLE;
        end
        S_SUM: begin
          if (rd_en) issue_cnt <= issue_cnt + NW'(1);
          if (s1_v && s1_ok) total <= total + TOT_W'(rd_data);
          if (issue_done && !s1_v) state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          plo   <= (SCALE_W+HALF)'(cur.draw) * (SCALE_W+HALF)'(total[HALF-1:0]);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi   <= (SCALE_W+TOT_W-HALF)'(cur.draw) *
                   (SCALE_W+TOT_W-HALF)'(total[TOT_W-1:HALF]);
          state <= S_LHS;
        end
        S_LHS: begin
          lhs       <= LHS_W'(plo) + (LHS_W'(phi) << HALF);
          scaled    <= '0;
          issue_cnt <= '0;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (rd_en) issue_cnt <= issue_cnt + NW'(1);
          if (s2_v && s2_ok && !hit) begin
            scaled <= scaled_next;
            if (lhs < scaled_next) begin
              hit     <= 1'b1;
              hit_idx <= s2_idx;
            end
          end
          if (hit || (issue_done && !s1_v && !s2_v)) begin
            emit  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/roulette_wheel_parent_select_core.sv]
`timescale 1ns / 1ps
// a load runs the 33-step reciprocal divider and then writes the table
// a select reads the first n = min(population_size, MAX_POPULATION) table entries:
// one pass over the fitness memory for the total, one pass for the prefix walk
// one item is worked at a time; a two-entry queue decouples input from the sequencer
// synchronous active-high reset clears valid bits, queue and goal registers;
// population size resets to 100
module roulette_wheel_parent_select_core import rws_pkg::*; #(
  parameter int MAX_POPULATION = MAX_POP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [GENE_W-1:0]    gene_a,
  input  logic [GENE_W-1:0]    gene_b,
  input  logic [GENE_W-1:0]    gene_c,
  input  logic [GENE_W-1:0]    draw,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    chosen_slot,
  output logic                 found,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GENE_W-1:0]    cfg_data
);

  localparam int NW = $clog2(MAX_POPULATION+1);

  logic [GENE_W-1:0] goal_a;
  logic [GENE_W-1:0] goal_b;
  logic [GENE_W-1:0] goal_c;
  logic [POP_W-1:0]  pop_size;
  logic [NW-1:0]     pop_n;
  logic              q_push;
  logic              q_ready;
  logic              q_valid;
  logic              q_pop;
  rws_item_t         q_in;
  rws_item_t         q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_a   <= '0;
      goal_b   <= '0;
      goal_c   <= '0;
      pop_size <= POP_W'(POP_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_A:   goal_a   <= cfg_data;
        CFG_GOAL_B:   goal_b   <= cfg_data;
        CFG_GOAL_C:   goal_c   <= cfg_data;
        CFG_POP_SIZE: pop_size <= cfg_data[POP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp population to the table
  assign pop_n = (int'(pop_size) > MAX_POPULATION) ? NW'(MAX_POPULATION) : NW'(pop_size);

  rws_front #(.MAX_POPULATION(MAX_POPULATION)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .slot(slot), .gene_a(gene_a), .gene_b(gene_b), .gene_c(gene_c),
    .draw(draw), .goal_a(goal_a), .goal_b(goal_b), .goal_c(goal_c),
    .q_push(q_push), .q_item(q_in), .q_ready(q_ready)
  );

  rws_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_in), .ready(q_ready),
    .pop(q_pop), .head_valid(q_valid), .head(q_head)
  );

  rws_back #(.MAX_POPULATION(MAX_POPULATION)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .pop_n(pop_n), .out_valid(out_valid), .out_stall(out_stall),
    .chosen_slot(chosen_slot), .found(found)
  );

endmodule

[src/rws_checker.sv]
`timescale 1ns / 1ps
module rws_checker import rws_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SLOT_W-1:0] chosen_slot,
  input logic              found
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_slot) && $stable(found))
    else $error("result beat changed while stalled");

  // a miss reports slot zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_slot == '0)
    else $error("miss with non-zero slot");

  // nothing comes out right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

  // front is empty after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind roulette_wheel_parent_select_core rws_checker u_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import rws_pkg::*;

  localparam int  N_SLOTS     = MAX_POP_DEF;
  localparam int  N_PHASES    = 8;
  localparam int  PHASE_ITEMS = 140;
  localparam int  SETTLE      = 400;
  localparam int  LONG_HOLD   = 1500;
  localparam longint LIMIT    = 5000000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } pick_t;

  typedef struct {
    logic              m;
    logic [SLOT_W-1:0] s;
    logic [GENE_W-1:0] ga, gb, gc, d;
    bit                typed;
    logic [SLOT_W-1:0] e_slot;
    logic              e_found;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, mode;
  logic [SLOT_W-1:0] slot;
  logic [GENE_W-1:0] gene_a, gene_b, gene_c, draw;
  logic out_valid, out_stall, found;
  logic [SLOT_W-1:0] chosen_slot;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GENE_W-1:0] cfg_data;

  // shadow copy of the block state
  logic [GENE_W-1:0] goal_a, goal_b, goal_c;
  logic [7:0]        pop_size;
  logic [FIT_W-1:0]  fit_tab [N_SLOTS];
  bit                occupied [N_SLOTS];

  pick_t pending_picks[$];
  int    errors;
  int    burst_left;
  bit    hold_req;
  longint cycles;
  row_t  rows[$];

  roulette_wheel_parent_select_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .slot(slot), .gene_a(gene_a), .gene_b(gene_b), .gene_c(gene_c),
    .draw(draw),
    .out_valid(out_valid), .out_stall(out_stall),
    .chosen_slot(chosen_slot), .found(found),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic longint unsigned gap_of(logic [GENE_W-1:0] x, logic [GENE_W-1:0] y);
    return (x > y) ? longint'(x - y) : longint'(y - x);
  endfunction

  // floor(2^32 / distance), saturated
  function automatic logic [FIT_W-1:0] fitness_for(logic [GENE_W-1:0] a,
                                                   logic [GENE_W-1:0] b,
                                                   logic [GENE_W-1:0] c);
    longint unsigned gap_sum, q;
    gap_sum = gap_of(a, goal_a) + gap_of(b, goal_b) + gap_of(c, goal_c);
    if (gap_sum == 0) return '1;
    q = (64'd1 << 32) / gap_sum;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[FIT_W-1:0];
  endfunction

  // roulette walk over the shadow table
  function automatic pick_t pick_parent(logic [GENE_W-1:0] d);
    longint unsigned total, prefix, lhs;
    int n;
    pick_t r;
    total = 0;
    prefix = 0;
    r.slot = '0;
    r.found = 1'b0;
    n = (pop_size > N_SLOTS) ? N_SLOTS : pop_size;
    for (int j = 0; j < n; j++)
      if (occupied[j]) total += fit_tab[j];
    lhs = longint'(d) * total;
    for (int j = 0; j < n; j++) begin
      if (occupied[j]) begin
        prefix += fit_tab[j];
        if (lhs < longint'(DRAW_SCALE) * prefix) begin
          r.slot = j[SLOT_W-1:0];
          r.found = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  // offer one beat in bursts with random gaps, wait for acceptance
  task automatic offer_beat(input row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    mode     <= r.m;
    slot     <= r.s;
    gene_a   <= r.ga;
    gene_b   <= r.gb;
    gene_c   <= r.gc;
    draw     <= r.d;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // send a beat and update the shadow state
  task automatic run_item(input row_t r);
    pick_t p;
    offer_beat(r);
    if (r.m == MODE_LOAD) begin
      fit_tab[r.s]  = fitness_for(r.ga, r.gb, r.gc);
      occupied[r.s] = 1'b1;
    end else begin
      p = pick_parent(r.d);
      if (r.typed) begin
        p.slot  = r.e_slot;
        p.found = r.e_found;
      end
      pending_picks.push_back(p);
    end
  endtask

  // wait until every pick is back and any trailing load has finished
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [GENE_W-1:0] a, input logic [GENE_W-1:0] b,
                            input logic [GENE_W-1:0] c, input logic [7:0] p);
    logic [GENE_W-1:0] vals [4];
    vals = '{a, b, c, {9'd0, p}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    goal_a = a;
    goal_b = b;
    goal_c = c;
    pop_size = p;
  endtask

  function automatic logic [GENE_W-1:0] near_goal(logic [GENE_W-1:0] g);
    int v;
    v = int'(g) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 131071) v = 131071;
    return v[GENE_W-1:0];
  endfunction

  function automatic row_t random_row();
    row_t r;
    int n;
    n = (pop_size == 0) ? 1 : ((pop_size > N_SLOTS) ? N_SLOTS : pop_size);
    r.typed = 1'b0;
    r.e_slot = '0;
    r.e_found = 1'b0;
    r.m = ($urandom_range(0, 9) < 4) ? MODE_LOAD : MODE_SELECT;
    r.s = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 127))
                                      : SLOT_W'($urandom_range(0, n - 1));
    if ($urandom_range(0, 3) == 0) begin
      r.ga = near_goal(goal_a);
      r.gb = near_goal(goal_b);
      r.gc = near_goal(goal_c);
    end else begin
      r.ga = GENE_W'($urandom_range(0, 131071));
      r.gb = GENE_W'($urandom_range(0, 131071));
      r.gc = GENE_W'($urandom_range(0, 131071));
    end
    r.d = ($urandom_range(0, 9) == 0) ? GENE_W'($urandom_range(100000, 131071))
                                      : GENE_W'($urandom_range(0, 99999));
    return r;
  endfunction

  // result side: compare beats, stall on a pattern of its own
  initial begin
    int pat, pat_left, hold_left;
    pick_t e;
    pat = 0;
    pat_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          $error("unexpected beat: chosen_slot %0d found %0d", chosen_slot, found);
          errors++;
        end else begin
          e = pending_picks.pop_front();
          if (chosen_slot !== e.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", e.slot, chosen_slot);
            errors++;
          end
          if (found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, found);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (pat_left == 0) begin
        pat = $urandom_range(0, 2);
        pat_left = $urandom_range(150, 400);
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (pat)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] pops [N_PHASES];
    logic [GENE_W-1:0] ga, gb, gc;
    errors = 0;
    burst_left = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_LOAD;
    slot = '0;
    gene_a = '0;
    gene_b = '0;
    gene_c = '0;
    draw = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GOAL_A;
    cfg_data = '0;
    goal_a = '0;
    goal_b = '0;
    goal_c = '0;
    pop_size = 8'(POP_RESET);
    for (int i = 0; i < N_SLOTS; i++) begin
      fit_tab[i] = '0;
      occupied[i] = 1'b0;
    end
    pops = '{8'd128, 8'd1, 8'd0, 8'd200, 8'd255, 8'd2, 8'd128, 8'd37};

    // directed rows, reset configuration
    rows = '{
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd0,      1, 7'd0, 1'b0},
      '{MODE_LOAD,   7'd0,   17'd0,      17'd0,     17'd0,      17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd0,      1, 7'd0, 1'b1},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd99999,  1, 7'd0, 1'b1},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd100000, 1, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'h1FFFF,  1, 7'd0, 1'b0},
      '{MODE_LOAD,   7'd127, 17'h1FFFF,  17'h1FFFF, 17'h1FFFF,  17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd99999,  1, 7'd0, 1'b1},
      '{MODE_LOAD,   7'd5,   17'd0,      17'd1,     17'd0,      17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd50000,  0, 7'd0, 1'b0},
      '{MODE_LOAD,   7'd0,   17'h1FFFF,  17'd0,     17'd0,      17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd99999,  0, 7'd0, 1'b0},
      '{MODE_LOAD,   7'd64,  17'd65536,  17'd1,     17'd2,      17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'd70000,  0, 7'd0, 1'b0},
      '{MODE_LOAD,   7'd99,  17'h15555,  17'h0AAAA, 17'h1FFFF,  17'd0,      0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'h0AAAA,  0, 7'd0, 1'b0},
      '{MODE_SELECT, 7'd0,   17'd0,      17'd0,     17'd0,      17'h1FFFF,  1, 7'd0, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) run_item(rows[i]);
    drain();

    // random phases, each under its own configuration
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) begin
        ga = 17'h1FFFF; gb = 17'h1FFFF; gc = 17'h1FFFF;
      end else if (p == 1) begin
        ga = '0; gb = '0; gc = '0;
      end else begin
        ga = GENE_W'($urandom_range(0, 131071));
        gb = GENE_W'($urandom_range(0, 131071));
        gc = GENE_W'($urandom_range(0, 131071));
      end
      set_config(ga, gb, gc, pops[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // receiver holds off while beats keep coming
        if ((p == 3 || p == 6) && k == 20) hold_req = 1'b1;
        run_item(random_row());
      end
      drain();
    end

    if (pending_picks.size() != 0) begin
      $error("%0d picks never arrived", pending_picks.size());
      errors++;
    end
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
